### sv/ckcrc_pkg.sv
package ckcrc_pkg;

    localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
    localparam int          CRC_W      = 32;
    localparam int          BYTE_W     = 8;
    localparam int          M_TDATA_W  = 32;

    typedef logic [CRC_W-1:0] crc_t;

    // One MSB-first shift of the CRC register
    function automatic crc_t crc_bit_step(input crc_t crc);
        crc_bit_step = crc[CRC_W-1] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
    endfunction

    function automatic crc_t swap_bytes(input crc_t v);
        swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

### sv/cksum_crc32_with_length_core.sv
// Bit-serial CRC-32 (POSIX cksum) with trailing length fold.
// A non-final byte is accepted, then takes 8 shift steps of the shared CRC unit.
// A final byte is shifted the same way, then the k (0..4) significant bytes of the count
// are folded in before the result is loaded; the result then waits in an output register.
// New bytes wait until the previous one is through the single one-bit CRC shift unit.
// Synchronous active-low reset clears CRC, count, overflow flag, config and output valid.
module cksum_crc32_with_length_core
    import ckcrc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,      // output_big_endian
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,        // data_byte
    input  logic                 s_tlast,        // last_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,        // checksum
    output logic                 m_tuser         // length_overflow
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_LOAD  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]  state_reg, state_next;
    crc_t        crc_reg, crc_next;
    crc_t        cnt_reg, cnt_next;
    crc_t        len_reg, len_next;
    logic        wrap_reg, wrap_next;
    logic        last_reg, last_next;
    logic        phase_reg, phase_next;     // 0: message byte, 1: length byte
    logic [2:0]  bit_reg, bit_next;
    logic        be_reg;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_sum_reg, m_sum_next;
    logic        m_ovf_reg, m_ovf_next;
    crc_t        crc_inv;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_sum_reg;
    assign m_tuser  = m_ovf_reg;
    assign crc_inv  = ~crc_reg;

    always_comb begin
        state_next   = state_reg;
        crc_next     = crc_reg;
        cnt_next     = cnt_reg;
        len_next     = len_reg;
        wrap_next    = wrap_reg;
        last_next    = last_reg;
        phase_next   = phase_reg;
        bit_next     = bit_reg;
        m_valid_next = m_valid_reg;
        m_sum_next   = m_sum_reg;
        m_ovf_next   = m_ovf_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    crc_next   = crc_reg ^ {s_tdata, {(CRC_W-BYTE_W){1'b0}}};
                    wrap_next  = wrap_reg | (cnt_reg == '1);
                    cnt_next   = cnt_reg + 32'd1;
                    last_next  = s_tlast;
                    phase_next = 1'b0;
                    bit_next   = '0;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                crc_next = crc_bit_step(crc_reg);
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7) begin
                    if (phase_reg) begin
                        len_next   = len_reg >> BYTE_W;
                        state_next = ST_LOAD;
                    end else if (last_reg) begin
                        len_next   = cnt_reg;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LOAD: begin
                // fold the next count byte, least significant first, while any remain
                if (len_reg != '0) begin
                    crc_next   = crc_reg ^ {len_reg[BYTE_W-1:0], {(CRC_W-BYTE_W){1'b0}}};
                    phase_next = 1'b1;
                    bit_next   = '0;
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_ovf_next   = wrap_reg;
                    m_sum_next   = wrap_reg ? '0 : (be_reg ? swap_bytes(crc_inv) : crc_inv);
                    crc_next     = '0;
                    cnt_next     = '0;
                    wrap_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            crc_reg     <= '0;
            cnt_reg     <= '0;
            wrap_reg    <= 1'b0;
            last_reg    <= 1'b0;
            phase_reg   <= 1'b0;
            bit_reg     <= '0;
            be_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            crc_reg     <= crc_next;
            cnt_reg     <= cnt_next;
            wrap_reg    <= wrap_next;
            last_reg    <= last_next;
            phase_reg   <= phase_next;
            bit_reg     <= bit_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                be_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        len_reg   <= len_next;
        m_sum_reg <= m_sum_next;
        m_ovf_reg <= m_ovf_next;
    end

endmodule
